// ----- hdl/spq_pkg.sv -----
package spq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_KEY_BITS    = 32;
    localparam int DEF_PRIO_BITS   = 16;

    localparam int OP_BITS     = 2;
    localparam int STATUS_BITS = 3;

    typedef enum logic [OP_BITS-1:0] {
        OP_ENQUEUE  = 2'd0,
        OP_DEQUEUE  = 2'd1,
        OP_DECREASE = 2'd2,
        OP_CLEAR    = 2'd3
    } t_op;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_NOT_LOWER = 3'd2,
        ST_NO_KEY    = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    // What every cell does on the coming clock edge
    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd cmd;  // broadcast to the whole row
        logic      occ;  // slot holds a live entry
        logic      rm;   // on remove: take the right neighbor's entry
    } t_cell_ctl;

endpackage

// ----- hdl/sorted_priority_queue.sv -----
// Sorted priority queue built as a row of QUEUE_DEPTH slot cells, front at cell 0,
// ordered by ascending priority number and then ascending key.
// Input channel (s side): one transaction per operation. tuser carries the
// operation (enqueue, dequeue, decrease priority, clear); tdata carries the
// key and the priority (new priority for decrease).
// Output channel (m side): exactly one result transaction per operation, with
// the removed entry (dequeue only), the front entry and count after the
// operation, and a status code in tuser.
// Timing: an operation is taken in the cycle after the previous one finished.
// Enqueue, dequeue, clear and a refused decrease run in the execute state
// only; a decrease that succeeds runs in the execute and then the reinsert
// state (remove, then reinsert). The result is registered and valid the cycle
// after the last execute cycle; the row takes a single shared command broadcast.
// The next operation is accepted while the previous result still waits in the
// output register; a held result stalls only the final execute cycle of the
// next operation until the output register frees.
// Reset clears the count and the control state; slot contents are not cleared
// and are never shown, since only positions below the count are read.
module sorted_priority_queue import spq_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int KEY_BITS    = DEF_KEY_BITS,
    parameter int PRIO_BITS   = DEF_PRIO_BITS,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1),
    parameter int IN_W        = KEY_BITS + PRIO_BITS,
    parameter int IN_TW       = ((IN_W + 7) / 8) * 8,
    parameter int OUT_W       = 2 * KEY_BITS + 2 * PRIO_BITS + CNT_W,
    parameter int OUT_TW      = ((OUT_W + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [IN_TW-1:0]  i_s_tdata,   // item_key, item_priority, zero fill
    input  logic [OP_BITS-1:0] i_s_tuser,  // op
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // taken_key, taken_priority, head_key, head_priority, entry_count, zero fill
    output logic [OUT_TW-1:0] o_m_tdata,
    output logic [STATUS_BITS-1:0] o_m_tuser  // status
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EXEC  = 3'b010,
        S_REINS = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;

    // Latched operation
    t_op                         r_op;
    logic        [KEY_BITS-1:0]  r_key;
    logic signed [PRIO_BITS-1:0] r_prio;

    // Output register
    logic                        r_out_valid;
    logic        [KEY_BITS-1:0]  r_taken_key;
    logic signed [PRIO_BITS-1:0] r_taken_prio;
    logic        [KEY_BITS-1:0]  r_head_key;
    logic signed [PRIO_BITS-1:0] r_head_prio;
    logic        [CNT_W-1:0]     r_out_count;
    t_status                     r_status;

    // Cell row
    logic        [KEY_BITS-1:0]  w_key      [QUEUE_DEPTH];
    logic signed [PRIO_BITS-1:0] w_prio     [QUEUE_DEPTH];
    logic        [KEY_BITS-1:0]  w_nxt_key  [QUEUE_DEPTH];
    logic signed [PRIO_BITS-1:0] w_nxt_prio [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_ins;
    logic [QUEUE_DEPTH-1:0] w_match;
    logic [QUEUE_DEPTH-1:0] w_occ;
    logic [QUEUE_DEPTH-1:0] w_rm;
    logic [QUEUE_DEPTH-1:0] w_first;
    t_cell_cmd              w_cmd;

    logic                        w_s_fire;
    logic                        w_out_free;
    logic                        w_found;
    logic signed [PRIO_BITS-1:0] w_sel_prio;
    logic                        w_load_out;
    t_status                     w_status;
    logic                        w_take;

    assign w_s_fire   = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || i_m_tready;

    // Frontmost matching slot, isolated as the lowest set bit
    assign w_found = |w_match;
    assign w_first = w_match & (~w_match + QUEUE_DEPTH'(1));

    always_comb begin
        w_sel_prio = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_sel_prio = w_sel_prio | (w_first[i] ? w_prio[i] : PRIO_BITS'(0));
        end
    end

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            t_cell_ctl                   w_ctl;
            logic        [KEY_BITS-1:0]  w_lkey;
            logic signed [PRIO_BITS-1:0] w_lprio;
            logic                        w_lins;
            logic        [KEY_BITS-1:0]  w_rkey;
            logic signed [PRIO_BITS-1:0] w_rprio;

            assign w_occ[g]  = (r_count > CNT_W'(g));
            assign w_ctl.cmd = w_cmd;
            assign w_ctl.occ = w_occ[g];
            assign w_ctl.rm  = w_rm[g];

            if (g == 0) begin : g_first
                assign w_lkey  = w_key[g];
                assign w_lprio = w_prio[g];
                assign w_lins  = 1'b0;
            end else begin : g_mid
                assign w_lkey  = w_key[g-1];
                assign w_lprio = w_prio[g-1];
                assign w_lins  = w_ins[g-1];
            end

            if (g == QUEUE_DEPTH - 1) begin : g_last
                assign w_rkey  = w_key[g];
                assign w_rprio = w_prio[g];
            end else begin : g_inner
                assign w_rkey  = w_key[g+1];
                assign w_rprio = w_prio[g+1];
            end

            spq_cell #(
                .KEY_BITS  (KEY_BITS),
                .PRIO_BITS (PRIO_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_new_key    (r_key),
                .i_new_prio   (r_prio),
                .i_left_key   (w_lkey),
                .i_left_prio  (w_lprio),
                .i_left_ins   (w_lins),
                .i_right_key  (w_rkey),
                .i_right_prio (w_rprio),
                .o_key        (w_key[g]),
                .o_prio       (w_prio[g]),
                .o_ins        (w_ins[g]),
                .o_match      (w_match[g]),
                .o_nxt_key    (w_nxt_key[g]),
                .o_nxt_prio   (w_nxt_prio[g])
            );
        end
    endgenerate

    // Sequencer: drive the row command, count and result
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        w_cmd      = CMD_HOLD;
        w_rm       = '0;
        w_load_out = 1'b0;
        w_status   = ST_OK;
        w_take     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_s_fire) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_op)
                    OP_ENQUEUE: begin
                        if (w_out_free) begin
                            w_load_out = 1'b1;
                            if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                                w_status = ST_FULL;
                            end else begin
                                w_cmd   = CMD_INSERT;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                    end
                    OP_DEQUEUE: begin
                        if (w_out_free) begin
                            w_load_out = 1'b1;
                            if (r_count == '0) begin
                                w_status = ST_EMPTY;
                            end else begin
                                w_cmd   = CMD_REMOVE;
                                w_rm    = '1;
                                w_take  = 1'b1;
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                    end
                    OP_DECREASE: begin
                        priority if (r_count == '0) begin
                            w_status   = ST_EMPTY;
                            w_load_out = w_out_free;
                        end else if (!w_found) begin
                            w_status   = ST_NO_KEY;
                            w_load_out = w_out_free;
                        end else if (w_sel_prio <= r_prio) begin
                            w_status   = ST_NOT_LOWER;
                            w_load_out = w_out_free;
                        end else begin
                            // drop the frontmost match, reinsert in S_REINS
                            w_cmd   = CMD_REMOVE;
                            w_rm    = ~(w_first - QUEUE_DEPTH'(1));
                            n_count = r_count - CNT_W'(1);
                            n_state = S_REINS;
                        end
                    end
                    OP_CLEAR: begin
                        if (w_out_free) begin
                            w_load_out = 1'b1;
                            n_count    = '0;
                        end
                    end
                    default: begin
                    end
                endcase
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            S_REINS: begin
                if (w_out_free) begin
                    w_cmd      = CMD_INSERT;
                    n_count    = r_count + CNT_W'(1);
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Latch the accepted transaction
    always_ff @(posedge i_clk) begin
        if (w_s_fire) begin
            r_op   <= t_op'(i_s_tuser);
            r_key  <= i_s_tdata[KEY_BITS-1:0];
            r_prio <= i_s_tdata[IN_W-1:KEY_BITS];
        end
    end

    // Result payload; the front comes from cell 0's next value
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_taken_key  <= w_take ? w_key[0]  : KEY_BITS'(0);
            r_taken_prio <= w_take ? w_prio[0] : PRIO_BITS'(0);
            r_head_key   <= (n_count == '0) ? KEY_BITS'(0)  : w_nxt_key[0];
            r_head_prio  <= (n_count == '0) ? PRIO_BITS'(0) : w_nxt_prio[0];
            r_out_count  <= n_count;
            r_status     <= w_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_status;
    assign o_m_tdata  = OUT_TW'({r_out_count, r_head_prio, r_head_key,
                                 r_taken_prio, r_taken_key});

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_reins_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REINS) |->
        (($past(r_state) == S_EXEC || $past(r_state) == S_REINS) && r_op == OP_DECREASE))
        else $error("reinsert not preceded by decrease removal");

    a_front_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |->
        !((w_prio[0] > w_prio[1]) || ((w_prio[0] == w_prio[1]) && (w_key[0] > w_key[1]))))
        else $error("front entries out of order");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_s_tready)
        else $error("input taken while an operation is executing");
`endif

endmodule

// ----- hdl/spq_cell.sv -----
module spq_cell import spq_pkg::*; #(
    parameter int KEY_BITS  = DEF_KEY_BITS,
    parameter int PRIO_BITS = DEF_PRIO_BITS
) (
    input  logic                        i_clk,
    input  t_cell_ctl                   i_ctl,
    input  logic        [KEY_BITS-1:0]  i_new_key,
    input  logic signed [PRIO_BITS-1:0] i_new_prio,
    input  logic        [KEY_BITS-1:0]  i_left_key,
    input  logic signed [PRIO_BITS-1:0] i_left_prio,
    input  logic                        i_left_ins,
    input  logic        [KEY_BITS-1:0]  i_right_key,
    input  logic signed [PRIO_BITS-1:0] i_right_prio,
    output logic        [KEY_BITS-1:0]  o_key,
    output logic signed [PRIO_BITS-1:0] o_prio,
    output logic                        o_ins,
    output logic                        o_match,
    output logic        [KEY_BITS-1:0]  o_nxt_key,
    output logic signed [PRIO_BITS-1:0] o_nxt_prio
);

    logic        [KEY_BITS-1:0]  r_key;
    logic signed [PRIO_BITS-1:0] r_prio;
    logic        [KEY_BITS-1:0]  n_key;
    logic signed [PRIO_BITS-1:0] n_prio;

    // Empty slots count as sorting after anything, so the insert flags
    // form a thermometer along the row.
    assign o_ins = !i_ctl.occ || (r_prio > i_new_prio) ||
                   ((r_prio == i_new_prio) && (r_key > i_new_key));
    assign o_match = i_ctl.occ && (r_key == i_new_key);

    always_comb begin
        n_key  = r_key;
        n_prio = r_prio;
        unique case (i_ctl.cmd)
            CMD_INSERT: begin
                if (i_left_ins) begin
                    n_key  = i_left_key;
                    n_prio = i_left_prio;
                end else if (o_ins) begin
                    n_key  = i_new_key;
                    n_prio = i_new_prio;
                end
            end
            CMD_REMOVE: begin
                if (i_ctl.rm) begin
                    n_key  = i_right_key;
                    n_prio = i_right_prio;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_prio <= n_prio;
    end

    assign o_key      = r_key;
    assign o_prio     = r_prio;
    assign o_nxt_key  = n_key;
    assign o_nxt_prio = n_prio;

endmodule
